@@ hw/rtl/sia_pkg.sv @@
// Shared opcodes, multiplier phases and controller/datapath interface structs for the ALU.
package sia_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_NEG   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIVAB = 4'd4,
    OP_DIVBA = 4'd5,
    OP_POW   = 4'd6,
    OP_LT    = 4'd7,
    OP_GT    = 4'd8,
    OP_LE    = 4'd9,
    OP_GE    = 4'd10,
    OP_NE    = 4'd11,
    OP_EQ    = 4'd12,
    OP_AND   = 4'd13,
    OP_OR    = 4'd14,
    OP_NOT   = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    MPH_LL = 2'd0,
    MPH_AH = 2'd1,
    MPH_BH = 2'd2
  } mph_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic div_step;
    logic div_fix;
    logic mul_en;
    mph_t mul_ph;
    logic pow_upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic div_zero;
    logic pow_trivial;
    logic ex_last;
    logic div_last;
  } sts_t;

endpackage

@@ hw/rtl/sia_mul.sv @@
// Truncating multiplier that builds a product from three half-width partial products.
module sia_mul #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  en,
  input  sia_pkg::mph_t         ph,
  input  logic [DATA_WIDTH-1:0] x,
  input  logic [DATA_WIDTH-1:0] y,
  output logic [DATA_WIDTH-1:0] prod
);
  import sia_pkg::*;

  localparam int HALF = (DATA_WIDTH + 1) / 2;
  localparam int HI   = DATA_WIDTH - HALF;

  logic [HALF-1:0]   ma;
  logic [HALF-1:0]   mb;
  logic [2*HALF-1:0] m;

  always_comb begin
    case (ph)
      MPH_AH: begin
        ma = HALF'(x[DATA_WIDTH-1:HALF]);
        mb = y[HALF-1:0];
      end
      MPH_BH: begin
        ma = x[HALF-1:0];
        mb = HALF'(y[DATA_WIDTH-1:HALF]);
      end
      default: begin
        ma = x[HALF-1:0];
        mb = y[HALF-1:0];
      end
    endcase
    m = ma * mb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ph == MPH_LL) begin
        prod <= m[DATA_WIDTH-1:0];
      end else begin
        prod <= prod + {m[HI-1:0], {HALF{1'b0}}};
      end
    end
  end

endmodule

@@ hw/rtl/sia_datapath.sv @@
// Datapath: operand registers, combinational ALU, restoring divider, power registers and output.
module sia_datapath #(
  parameter int DATA_WIDTH = 64
) (
  input  logic          clk,
  input  sia_pkg::cmd_t cmd,
  output sia_pkg::sts_t sts,
  input  logic [127:0]  s_tdata,
  input  logic [3:0]    s_tuser,
  output logic [63:0]   out_data,
  output logic          out_dz
);
  import sia_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH);

  op_t                         opr;
  logic signed [DATA_WIDTH-1:0] a;
  logic signed [DATA_WIDTH-1:0] b;
  logic signed [DATA_WIDTH-1:0] res;
  logic                        dz;
  logic [DATA_WIDTH-1:0]       acc;
  logic [DATA_WIDTH-1:0]       base;
  logic [DATA_WIDTH-1:0]       ex;
  logic [DATA_WIDTH-1:0]       rem;
  logic [DATA_WIDTH-1:0]       quo;
  logic [DATA_WIDTH-1:0]       dreg;
  logic                        dneg;
  logic [CW-1:0]               cnt;

  logic [DATA_WIDTH-1:0] alu;
  logic [DATA_WIDTH-1:0] num_sel;
  logic [DATA_WIDTH-1:0] den_sel;
  logic [DATA_WIDTH-1:0] num_mag;
  logic [DATA_WIDTH-1:0] den_mag;
  logic                  is_div;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] prod_a;
  logic [DATA_WIDTH-1:0] prod_b;
  logic [DATA_WIDTH-1:0] acc_new;

  always_comb begin
    case (opr) inside
      OP_ADD:                   alu = a + b;
      OP_SUB:                   alu = a - b;
      OP_NEG:                   alu = '0 - a;
      OP_POW:                   alu = DATA_WIDTH'(b == '0);
      OP_LT:                    alu = DATA_WIDTH'(a < b);
      OP_GT:                    alu = DATA_WIDTH'(b < a);
      OP_LE:                    alu = DATA_WIDTH'(!(b < a));
      OP_GE:                    alu = DATA_WIDTH'(!(a < b));
      OP_NE:                    alu = DATA_WIDTH'(a != b);
      OP_EQ:                    alu = DATA_WIDTH'(a == b);
      OP_AND:                   alu = DATA_WIDTH'((a != '0) && (b != '0));
      OP_OR:                    alu = DATA_WIDTH'((a != '0) || (b != '0));
      OP_NOT:                   alu = DATA_WIDTH'(a == '0);
      OP_MUL, OP_DIVAB, OP_DIVBA: alu = '0;
    endcase
  end

  always_comb begin
    is_div  = (opr == OP_DIVAB) || (opr == OP_DIVBA);
    num_sel = (opr == OP_DIVBA) ? b : a;
    den_sel = (opr == OP_DIVBA) ? a : b;
    num_mag = num_sel[DATA_WIDTH-1] ? ('0 - num_sel) : num_sel;
    den_mag = den_sel[DATA_WIDTH-1] ? ('0 - den_sel) : den_sel;
    shifted = {rem, quo[DATA_WIDTH-1]};
    diff    = shifted - {1'b0, dreg};
    acc_new = ex[0] ? prod_a : acc;
  end

  sia_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul_acc (
    .clk  (clk),
    .en   (cmd.mul_en),
    .ph   (cmd.mul_ph),
    .x    (acc),
    .y    (base),
    .prod (prod_a)
  );

  sia_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul_sq (
    .clk  (clk),
    .en   (cmd.mul_en),
    .ph   (cmd.mul_ph),
    .x    (base),
    .y    (base),
    .prod (prod_b)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opr <= op_t'(s_tuser);
      a   <= s_tdata[DATA_WIDTH-1:0];
      b   <= s_tdata[64+DATA_WIDTH-1:64];
    end
    if (cmd.setup) begin
      res  <= alu;
      dz   <= is_div && (den_sel == '0);
      rem  <= '0;
      quo  <= num_mag;
      dreg <= den_mag;
      dneg <= num_sel[DATA_WIDTH-1] ^ den_sel[DATA_WIDTH-1];
      cnt  <= CW'(DATA_WIDTH - 1);
      if (opr == OP_MUL) begin
        acc  <= a;
        base <= b;
        ex   <= DATA_WIDTH'(1);
      end else begin
        acc  <= DATA_WIDTH'(1);
        base <= a;
        ex   <= b;
      end
    end
    if (cmd.div_step) begin
      if (!diff[DATA_WIDTH]) begin
        rem <= diff[DATA_WIDTH-1:0];
      end else begin
        rem <= shifted[DATA_WIDTH-1:0];
      end
      quo <= {quo[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
      cnt <= cnt - CW'(1);
    end
    if (cmd.div_fix) begin
      res <= dneg ? ('0 - quo) : quo;
    end
    if (cmd.pow_upd) begin
      acc  <= acc_new;
      base <= prod_b;
      ex   <= ex >> 1;
      res  <= acc_new;
    end
    if (cmd.out_load) begin
      out_data <= 64'(res);
      out_dz   <= dz;
    end
  end

  always_comb begin
    sts.op          = opr;
    sts.div_zero    = (den_sel == '0);
    sts.pow_trivial = (b == '0) || b[DATA_WIDTH-1] || (a == '0);
    sts.ex_last     = (ex[DATA_WIDTH-1:1] == '0);
    sts.div_last    = (cnt == '0);
  end

endmodule

@@ hw/rtl/sia_ctrl.sv @@
// Controller state machine that sequences each operation and owns the handshake flags.
module sia_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  sia_pkg::sts_t sts,
  output sia_pkg::cmd_t cmd
);
  import sia_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SETUP = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_DFIX  = 9'b000001000,
    S_MUL0  = 9'b000010000,
    S_MUL1  = 9'b000100000,
    S_MUL2  = 9'b001000000,
    S_PUPD  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_ph = MPH_LL;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        case (sts.op) inside
          OP_DIVAB, OP_DIVBA: state_next = sts.div_zero ? S_FIN : S_DIV;
          OP_POW:             state_next = sts.pow_trivial ? S_FIN : S_MUL0;
          OP_MUL:             state_next = S_MUL0;
          default:            state_next = S_FIN;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DFIX;
        end
      end
      S_DFIX: begin
        cmd.div_fix = 1'b1;
        state_next  = S_FIN;
      end
      S_MUL0: begin
        cmd.mul_en = 1'b1;
        cmd.mul_ph = MPH_LL;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_ph = MPH_AH;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_ph = MPH_BH;
        state_next = S_PUPD;
      end
      S_PUPD: begin
        cmd.pow_upd = 1'b1;
        state_next  = sts.ex_last ? S_FIN : S_MUL0;
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  assign s_tready = (state == S_IDLE);

endmodule

@@ hw/rtl/signed_integer_alu_with_power.sv @@
// Top level of the signed integer ALU with power: controller, datapath and checks.
//
// One request transaction on the s_ channel carries an opcode in s_tuser and two signed
// operands in s_tdata; one response transaction on the m_ channel returns the signed
// result in m_tdata and the divide-by-zero flag in m_tuser. Arithmetic is done at
// DATA_WIDTH bits and the result is sign-extended to 64 bits.
// Controller sequence after acceptance, by operation, each ending in the output load:
//   add, sub, neg, compare, logic, zero divisor, trivial power: setup only
//   multiply: setup, three half-width partial products, then one update
//   divide: setup, restoring divider (one quotient bit per cycle), then sign fix
//   power: setup; per significant exponent bit, square and multiply side by side, update
// A new request is taken in the cycle after the previous one has been moved to the
// output register; no request is accepted while another one is in progress.
// The output register holds one response; while it waits for m_tready the block still
// accepts and computes the next request, then holds it until the register is free.
// Reset (rst, synchronous) returns the controller to idle and empties the output.
module signed_integer_alu_with_power #(
  parameter int DATA_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // operand_a [63:0], operand_b [127:64]
  input  logic [3:0]   s_tuser,  // req_type [3:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // result [63:0]
  output logic [0:0]   m_tuser   // divide_by_zero [0]
);
  import sia_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_dz;

  sia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sia_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .out_data (m_tdata),
    .out_dz   (out_dz)
  );

  assign m_tuser[0] = out_dz;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("Waiting response overwritten.");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("Loaded response not presented.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("Request accepted while a request is in progress.");

  a_dz_result_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0))
    else $error("Divide-by-zero response carries a non-zero result.");

endmodule
